// ----- hw/rtl/pwo_pkg.sv -----
`timescale 1ns / 1ps

package pwo_pkg;

  // Coordinate width of vertices and window edges
  localparam int CoordWidth   = 24;
  // One more bit holds any difference of two coordinates
  localparam int DiffWidth    = CoordWidth + 1;
  localparam int ProdWidth    = 2 * DiffWidth;
  localparam int InDataWidth  = ((2 * CoordWidth + 7) / 8) * 8;
  localparam int OutDataWidth = 8;
  localparam int CfgIdxWidth  = 2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [ProdWidth:0]    cross_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgXMin = 2'd0,
    CfgYMin = 2'd1,
    CfgXMax = 2'd2,
    CfgYMax = 2'd3
  } cfg_index_e;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } window_t;

  // Load enables of the two datapath stages
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

// ----- hw/rtl/pwo_seg.sv -----
`timescale 1ns / 1ps

module pwo_seg (
  input  logic               clk_i,
  input  pwo_pkg::stage_en_t en_i,
  input  pwo_pkg::window_t   window_i,
  input  pwo_pkg::coord_t    x1_i,
  input  pwo_pkg::coord_t    y1_i,
  input  pwo_pkg::coord_t    x2_i,
  input  pwo_pkg::coord_t    y2_i,
  output logic               hit_o
);
  import pwo_pkg::*;

  // Stage 1: endpoint tests, trivial rejects, differences
  logic  in1, in2, rej, axis, same_sign, dec, dec_hit;
  diff_t dx, dy, xa, ya, xb, yb;

  always_comb begin
    in1 = (x1_i >= window_i.x_min) && (x1_i <= window_i.x_max) &&
          (y1_i >= window_i.y_min) && (y1_i <= window_i.y_max);
    in2 = (x2_i >= window_i.x_min) && (x2_i <= window_i.x_max) &&
          (y2_i >= window_i.y_min) && (y2_i <= window_i.y_max);
    rej = ((x1_i < window_i.x_min) && (x2_i < window_i.x_min)) ||
          ((x1_i > window_i.x_max) && (x2_i > window_i.x_max)) ||
          ((y1_i < window_i.y_min) && (y2_i < window_i.y_min)) ||
          ((y1_i > window_i.y_max) && (y2_i > window_i.y_max));
    dx   = diff_t'(x2_i) - diff_t'(x1_i);
    dy   = diff_t'(y2_i) - diff_t'(y1_i);
    axis = (dx == '0) || (dy == '0);
    same_sign = (dx[DiffWidth-1] == dy[DiffWidth-1]);
    // Pick the window diagonal that crosses the segment direction
    xa = (same_sign ? diff_t'(window_i.x_max) : diff_t'(window_i.x_min)) - diff_t'(x1_i);
    xb = (same_sign ? diff_t'(window_i.x_min) : diff_t'(window_i.x_max)) - diff_t'(x1_i);
    ya = diff_t'(window_i.y_min) - diff_t'(y1_i);
    yb = diff_t'(window_i.y_max) - diff_t'(y1_i);
    dec     = in1 || in2 || rej || axis;
    dec_hit = in1 || in2 || !rej;
  end

  logic  dec_s1_q, dec_hit_s1_q;
  diff_t dx_q, dy_q, xa_q, ya_q, xb_q, yb_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      dec_s1_q     <= dec;
      dec_hit_s1_q <= dec_hit;
      dx_q <= dx;
      dy_q <= dy;
      xa_q <= xa;
      ya_q <= ya;
      xb_q <= xb;
      yb_q <= yb;
    end
  end

  // Stage 2: the four cross-product terms
  logic  dec_s2_q, dec_hit_s2_q;
  prod_t pa1_q, pa2_q, pb1_q, pb2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      dec_s2_q     <= dec_s1_q;
      dec_hit_s2_q <= dec_hit_s1_q;
      pa1_q <= dx_q * ya_q;
      pa2_q <= dy_q * xa_q;
      pb1_q <= dx_q * yb_q;
      pb2_q <= dy_q * xb_q;
    end
  end

  // Sign of each cross product, then compare
  cross_t sa, sb;
  logic   cross_hit;

  always_comb begin
    sa = cross_t'(pa1_q) - cross_t'(pa2_q);
    sb = cross_t'(pb1_q) - cross_t'(pb2_q);
    cross_hit = (sa == '0) || (sb == '0) || (sa[ProdWidth] != sb[ProdWidth]);
    hit_o = dec_s2_q ? dec_hit_s2_q : cross_hit;
  end

endmodule

// ----- hw/rtl/polyline_window_overlap.sv -----
`timescale 1ns / 1ps

// Polyline against window overlap test.
// Slave stream: one vertex per word. tdata carries vertex_x (low bits) and
// vertex_y, tuser marks the first vertex of a polyline, tlast the last one.
// A vertex with tuser low while no polyline is open starts a new polyline.
// Master stream: one word per polyline, sent when its last vertex is
// processed; tdata bit 0 is the overlap flag, the upper bits are zero.
// A one-vertex polyline reports no overlap.
// The window is set through the write port (index 0..3: x_min, y_min,
// x_max, y_max); write it only while no polyline is in flight.
// Throughput: one vertex per cycle unless a last vertex meets a full result
// register. The only feedback is the previous vertex at the input and the
// latched hit at the end of the pipe. Path to out tvalid for a last vertex:
// input register, difference stage, multiplier stage, result register.
// Reset clears the window to zero, closes any open polyline and empties
// the pipe. When the receiver stalls, vertices that end no polyline keep
// draining; input backs up only once a last vertex meets a full result
// register.
module polyline_window_overlap (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [23:0] vertex_x, [47:24] vertex_y
  input  logic [pwo_pkg::InDataWidth-1:0]         s_axis_tdata_i,
  // [0] first_vertex
  input  logic                                    s_axis_tuser_i,
  input  logic                                    s_axis_tlast_i,
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // [0] overlap, [7:1] zero
  output logic [pwo_pkg::OutDataWidth-1:0]        m_axis_tdata_o,
  input  logic                                    cfg_we_i,
  input  logic [pwo_pkg::CfgIdxWidth-1:0]         cfg_index_i,
  input  logic [pwo_pkg::CoordWidth-1:0]          cfg_data_i
);
  import pwo_pkg::*;

  // Window registers
  window_t win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgXMin: win_q.x_min <= coord_t'(cfg_data_i);
        CfgYMin: win_q.y_min <= coord_t'(cfg_data_i);
        CfgXMax: win_q.x_max <= coord_t'(cfg_data_i);
        CfgYMax: win_q.y_max <= coord_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Handshake and stage advance
  logic v0_q, v1_q, v2_q;
  logic last0_q, last1_q, last2_q;
  logic rst0_q, rst1_q, rst2_q;
  logic out_free, ret2, rdy0, rdy1, rdy2, accept;
  stage_en_t en;

  always_comb begin
    out_free = !m_axis_tvalid_o || m_axis_tready_i;
    // Only a last vertex needs the result register
    ret2 = v2_q && (!last2_q || out_free);
    rdy2 = !v2_q || ret2;
    rdy1 = !v1_q || rdy2;
    rdy0 = !v0_q || rdy1;
    en.s1 = rdy1;
    en.s2 = rdy2;
    accept = s_axis_tvalid_i && rdy0;
  end

  assign s_axis_tready_o = rdy0;

  // Previous vertex tracking, done at accept
  coord_t in_x, in_y;
  coord_t prev_x_q, prev_y_q;
  logic   have_prev_q;
  coord_t x1_q, y1_q, x2_q, y2_q;

  assign in_x = coord_t'(s_axis_tdata_i[CoordWidth-1:0]);
  assign in_y = coord_t'(s_axis_tdata_i[2*CoordWidth-1:CoordWidth]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
    end else if (accept) begin
      have_prev_q <= !s_axis_tlast_i;
      prev_x_q    <= in_x;
      prev_y_q    <= in_y;
    end
  end

  // Input register: segment endpoints
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q <= prev_x_q;
      y1_q <= prev_y_q;
      x2_q <= in_x;
      y2_q <= in_y;
    end
  end

  // Control pipe: valid, last, restart (no segment for this vertex)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;  v1_q <= 1'b0;  v2_q <= 1'b0;
      last0_q <= 1'b0;  last1_q <= 1'b0;  last2_q <= 1'b0;
      rst0_q <= 1'b0;  rst1_q <= 1'b0;  rst2_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q    <= s_axis_tvalid_i;
        last0_q <= s_axis_tlast_i;
        rst0_q  <= s_axis_tuser_i || !have_prev_q;
      end
      if (rdy1) begin
        v1_q    <= v0_q;
        last1_q <= last0_q;
        rst1_q  <= rst0_q;
      end
      if (rdy2) begin
        v2_q    <= v1_q;
        last2_q <= last1_q;
        rst2_q  <= rst1_q;
      end
    end
  end

  logic seg_hit;

  pwo_seg u_seg (
    .clk_i    (clk_i),
    .en_i     (en),
    .window_i (win_q),
    .x1_i     (x1_q),
    .y1_i     (y1_q),
    .x2_i     (x2_q),
    .y2_i     (y2_q),
    .hit_o    (seg_hit)
  );

  // Hit latch and result register
  logic hit_q, hit_d, acc_or;
  logic out_v_q, out_v_d, overlap_q, overlap_d;

  always_comb begin
    acc_or    = !rst2_q && (hit_q || seg_hit);
    hit_d     = hit_q;
    out_v_d   = out_v_q;
    overlap_d = overlap_q;
    if (out_v_q && m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
    if (ret2) begin
      // Close the polyline on its last vertex
      hit_d = last2_q ? 1'b0 : acc_or;
      if (last2_q) begin
        out_v_d   = 1'b1;
        overlap_d = acc_or;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      hit_q   <= hit_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_q <= overlap_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(OutDataWidth-1){1'b0}}, overlap_q};

  // A last vertex leaving the pipe always shows up as a result
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ret2 && last2_q) |=> out_v_q)
    else $error("last vertex retired without a result");

  // A vertex that ends no polyline never blocks the pipe
  a_nonlast_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !last2_q) |-> ret2)
    else $error("non-last vertex held in the pipe");

  // One-vertex polyline reports no overlap
  a_single_vertex_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ret2 && last2_q && rst2_q) |=> (out_v_q && !overlap_q))
    else $error("one-vertex polyline reported overlap");

  // Input backs up only behind a full pipe
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v0_q && v1_q && v2_q && last2_q && out_v_q))
    else $error("input stalled with room in the pipe");

endmodule

// ----- tb/sv/polyline_window_overlap_tb.sv -----
`timescale 1ns / 1ps

module polyline_window_overlap_tb;
  import pwo_pkg::*;

  localparam longint CoordLo    = -(64'sd1 <<< (CoordWidth - 1));
  localparam longint CoordHi    = (64'sd1 <<< (CoordWidth - 1)) - 1;
  localparam int     CycleLimit = 600000;
  // Room for the pipe to empty after the last vertex, with margin
  localparam int     PipeSettle = 8;
  localparam int     RandPhases = 9;
  localparam int     PhaseWords = 120;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     is_first;
    bit     is_last;
  } vertex_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [InDataWidth-1:0]  s_axis_tdata_i  = '0;
  logic                    s_axis_tuser_i  = 1'b0;
  logic                    s_axis_tlast_i  = 1'b0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata_o;
  logic                    cfg_we_i        = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index_i     = '0;
  logic [CoordWidth-1:0]   cfg_data_i      = '0;

  // Window as the block should see it, sign-extended
  longint  win_x_min, win_y_min, win_x_max, win_y_max;
  // Open polyline state: previous vertex and the latched hit
  longint  prev_x, prev_y;
  bit      poly_open, hit_latched;

  vertex_t vertex_q[$];     // vertices waiting for the driver
  bit      overlap_q[$];    // overlap flags still owed by the block
  vertex_t cur_vertex;
  int      vertices_unsent;
  int      vertices_queued;
  int      mismatch_count;
  int      send_gap, stall_left;
  bit      steady_send, steady_recv;
  int      cycle_count;

  polyline_window_overlap dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    // [23:0] vertex_x, [47:24] vertex_y
    .s_axis_tdata_i  (s_axis_tdata_i),
    // [0] first_vertex
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    // [0] overlap, [7:1] zero
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Overlap prediction
  // ---------------------------------------------------------------------

  function automatic bit in_window(longint x, longint y);
    return x >= win_x_min && x <= win_x_max && y >= win_y_min && y <= win_y_max;
  endfunction

  // Exact segment test; 64-bit products cannot overflow at 25-bit deltas
  function automatic bit segment_touches(longint x1, longint y1, longint x2, longint y2);
    longint dx, dy, xa, ya, xb, yb, cross_a, cross_b;
    if (in_window(x1, y1) || in_window(x2, y2)) return 1'b1;
    // Both endpoints beyond the same edge: trivial miss
    if (x1 < win_x_min && x2 < win_x_min) return 1'b0;
    if (x1 > win_x_max && x2 > win_x_max) return 1'b0;
    if (y1 < win_y_min && y2 < win_y_min) return 1'b0;
    if (y1 > win_y_max && y2 > win_y_max) return 1'b0;
    dx = x2 - x1;
    dy = y2 - y1;
    // Axis-parallel survivors always cross the window band
    if (dx == 0 || dy == 0) return 1'b1;
    // Pick the two corners on the diagonal across the segment direction
    if ((dx < 0) == (dy < 0)) begin
      xa = win_x_max - x1; ya = win_y_min - y1;
      xb = win_x_min - x1; yb = win_y_max - y1;
    end else begin
      xa = win_x_min - x1; ya = win_y_min - y1;
      xb = win_x_max - x1; yb = win_y_max - y1;
    end
    cross_a = dx * ya - dy * xa;
    cross_b = dx * yb - dy * xb;
    // Line through a corner counts as touching
    if (cross_a == 0 || cross_b == 0) return 1'b1;
    return (cross_a < 0) != (cross_b < 0);
  endfunction

  // Advance the polyline state by one accepted vertex
  function automatic void fold_vertex(vertex_t v);
    if (v.is_first || !poly_open) begin
      hit_latched = 1'b0;
    end else if (segment_touches(prev_x, prev_y, longint'(v.x), longint'(v.y))) begin
      hit_latched = 1'b1;
    end
    prev_x    = longint'(v.x);
    prev_y    = longint'(v.y);
    poly_open = 1'b1;
    if (v.is_last) begin
      overlap_q.push_back(hit_latched);
      poly_open   = 1'b0;
      hit_latched = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long; none in steady mode
  function automatic int pick_idle(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v < CoordLo) return CoordLo;
    if (v > CoordHi) return CoordHi;
    return v;
  endfunction

  // Coordinate around the window span, on its edges, or anywhere at all
  function automatic longint near_coord(longint lo, longint hi);
    longint a, b, margin;
    int unsigned r;
    r = $urandom_range(0, 99);
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    if (r < 10) return longint'(coord_t'($urandom()));
    if (r < 22) return ($urandom_range(0, 1) != 0) ? lo : hi;
    margin = (b - a) / 2 + 4 + longint'($urandom_range(0, 32));
    return clamp_coord(a - margin +
                       longint'($urandom_range(0, 32'(b - a + 2 * margin))));
  endfunction

  function automatic longint pick_half_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return longint'($urandom_range(0, 20));
    if (r < 70) return longint'($urandom_range(0, 3000));
    return longint'($urandom_range(0, 1 << 22));
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------

  task automatic queue_vertex(longint x, longint y, bit is_first, bit is_last);
    vertex_t v;
    v.x        = coord_t'(x);
    v.y        = coord_t'(y);
    v.is_first = is_first;
    v.is_last  = is_last;
    vertex_q.push_back(v);
    vertices_unsent++;
    vertices_queued++;
  endtask

  // Mostly well-formed polylines; a few start without the first flag,
  // restart midway, or run on into the next one without a last flag
  task automatic queue_polyline(bit may_break);
    int unsigned len, r, k;
    bit first_flag, last_flag;
    r = $urandom_range(0, 99);
    if (r < 10) len = 1;
    else if (r < 85) len = $urandom_range(2, 5);
    else len = $urandom_range(6, 20);
    for (k = 0; k < len; k++) begin
      if (k == 0) first_flag = ($urandom_range(0, 9) != 0);
      else first_flag = ($urandom_range(0, 39) == 0);
      last_flag = (k == len - 1) && !(may_break && $urandom_range(0, 19) == 0);
      queue_vertex(near_coord(win_x_min, win_x_max), near_coord(win_y_min, win_y_max),
                   first_flag, last_flag);
    end
  endtask

  // Write all four window registers back to back; only call while idle
  task automatic set_window(longint x_min, longint y_min, longint x_max, longint y_max);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgXMin;
    cfg_data_i  <= coord_t'(x_min);
    @(posedge clk_i);
    cfg_index_i <= CfgYMin;
    cfg_data_i  <= coord_t'(y_min);
    @(posedge clk_i);
    cfg_index_i <= CfgXMax;
    cfg_data_i  <= coord_t'(x_max);
    @(posedge clk_i);
    cfg_index_i <= CfgYMax;
    cfg_data_i  <= coord_t'(y_max);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    win_x_min = x_min;
    win_y_min = y_min;
    win_x_max = x_max;
    win_y_max = y_max;
  endtask

  // Hold until every vertex is taken and every overlap word is back,
  // then let the pipe settle in case trailing vertices closed no polyline
  task automatic wait_drained();
    while (vertices_unsent != 0 || overlap_q.size() != 0) @(posedge clk_i);
    repeat (PipeSettle) @(posedge clk_i);
  endtask

  task automatic random_window(output longint x_min, output longint y_min,
                               output longint x_max, output longint y_max);
    longint cx, cy, hx, hy;
    cx = longint'(coord_t'($urandom()));
    cy = longint'(coord_t'($urandom()));
    hx = pick_half_size();
    hy = pick_half_size();
    x_min = clamp_coord(cx - hx);
    x_max = clamp_coord(cx + hx);
    y_min = clamp_coord(cy - hy);
    y_max = clamp_coord(cy + hy);
  endtask

  // ---------------------------------------------------------------------
  // Sequencer: reset, directed polylines, then random phases
  // ---------------------------------------------------------------------

  initial begin
    longint x0, y0, x1, y1, swap;
    int phase, target;
    win_x_min = 0; win_y_min = 0; win_x_max = 0; win_y_max = 0;
    prev_x = 0; prev_y = 0; poly_open = 1'b0; hit_latched = 1'b0;
    vertices_unsent = 0; vertices_queued = 0; mismatch_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window is the single point at the origin: cross it diagonally
    queue_vertex(-3, -3, 1'b1, 1'b0);
    queue_vertex(3, 3, 1'b0, 1'b1);
    wait_drained();

    set_window(-100, -50, 200, 80);
    // One-vertex polyline inside the window still reports no overlap
    queue_vertex(0, 0, 1'b1, 1'b1);
    // Endpoint exactly on the upper-left corner
    queue_vertex(-200, 100, 1'b1, 1'b0);
    queue_vertex(-100, 80, 1'b0, 1'b1);
    // Segments rejected past the left, upper, right and lower edges
    queue_vertex(-200, -500, 1'b1, 1'b0);
    queue_vertex(-150, 500, 1'b0, 1'b0);
    queue_vertex(300, 500, 1'b0, 1'b0);
    queue_vertex(300, -500, 1'b0, 1'b0);
    queue_vertex(-500, -100, 1'b0, 1'b1);
    // Vertical segment spanning the window
    queue_vertex(50, -300, 1'b1, 1'b0);
    queue_vertex(50, 300, 1'b0, 1'b1);
    // Diagonal passing above the upper-left corner
    queue_vertex(-300, 0, 1'b1, 1'b0);
    queue_vertex(0, 300, 1'b0, 1'b1);
    // Diagonal grazing the upper-right corner exactly
    queue_vertex(100, 180, 1'b1, 1'b0);
    queue_vertex(300, -20, 1'b0, 1'b1);
    // Falling diagonal through the window
    queue_vertex(-300, 100, 1'b1, 1'b0);
    queue_vertex(300, -100, 1'b0, 1'b1);
    // No open polyline: a vertex without the first flag opens one
    queue_vertex(-150, 0, 1'b0, 1'b0);
    queue_vertex(10, 10, 1'b0, 1'b1);
    // Horizontal hit, then a restart that drops the latched hit
    queue_vertex(-300, 0, 1'b1, 1'b0);
    queue_vertex(300, 0, 1'b0, 1'b0);
    queue_vertex(-300, 500, 1'b1, 1'b0);
    queue_vertex(-200, 500, 1'b0, 1'b1);
    // Coordinate extremes, corner to corner of the grid
    queue_vertex(CoordLo, CoordLo, 1'b1, 1'b0);
    queue_vertex(CoordHi, CoordHi, 1'b0, 1'b1);
    wait_drained();

    for (phase = 0; phase < RandPhases; phase++) begin
      random_window(x0, y0, x1, y1);
      case (phase)
        1: begin
          // Whole grid
          x0 = CoordLo; y0 = CoordLo; x1 = CoordHi; y1 = CoordHi;
        end
        2: begin
          // Single-point window
          x1 = x0; y1 = y0;
        end
        3: begin
          // Inverted window: min above max on both axes
          swap = x0; x0 = x1 + 1; x1 = swap;
          swap = y0; y0 = y1 + 1; y1 = swap;
          x0 = clamp_coord(x0); y0 = clamp_coord(y0);
        end
        4: begin
          // Edges pinned at the grid extremes
          x0 = CoordLo; y1 = CoordHi;
        end
        default: ;
      endcase
      set_window(x0, y0, x1, y1);
      target = vertices_queued + PhaseWords;
      while (vertices_queued < target) queue_polyline(1'b1);
      queue_polyline(1'b0);
      // Sender holds off here until every result of the phase is back
      wait_drained();
    end

    if (mismatch_count == 0 && overlap_q.size() == 0) begin
      $display("polyline_window_overlap verification clean");
    end else begin
      $display("polyline_window_overlap verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: one vertex word per handshake, random gaps between words
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      send_gap    = 0;
      steady_send = 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        fold_vertex(cur_vertex);
        vertices_unsent--;
      end
      if ($urandom_range(0, 199) == 0) steady_send = !steady_send;
      // Present a new word only when the current one is gone
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (vertex_q.size() > 0) begin
          cur_vertex = vertex_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {cur_vertex.y, cur_vertex.x};
          s_axis_tuser_i  <= cur_vertex.is_first;
          s_axis_tlast_i  <= cur_vertex.is_last;
          send_gap = pick_idle(steady_send);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random backpressure, compare each word with the oldest flag
  // ---------------------------------------------------------------------

  function automatic void flag_mismatch(string what, int expected, int actual);
    if (mismatch_count < 10) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what, expected, actual);
    end
    mismatch_count++;
  endfunction

  always @(posedge clk_i) begin
    bit want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left  = 0;
      steady_recv = 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (overlap_q.size() == 0) begin
          // Word with nothing owed: expected is reported as -1
          flag_mismatch("unexpected overlap word", -1, int'(m_axis_tdata_o));
        end else begin
          want = overlap_q.pop_front();
          if (m_axis_tdata_o[0] !== want) begin
            flag_mismatch("overlap", int'(want), int'(m_axis_tdata_o[0]));
          end
          if (m_axis_tdata_o[OutDataWidth-1:1] !== '0) begin
            flag_mismatch("tdata padding", 0, int'(m_axis_tdata_o[OutDataWidth-1:1]));
          end
        end
      end
      if ($urandom_range(0, 199) == 0) steady_recv = !steady_recv;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = pick_idle(steady_recv);
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("polyline_window_overlap verification failed");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
